/* rtl/sgr_pkg.sv */
// sgr_pkg: shared types and constants for the stream group reverser
// used by every rtl file of the block; depends on nothing

package sgr_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;
    // group count field; wide enough for groups of up to 64 words
    localparam int CNT_W   = 7;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd1;

    // one drain job handed from the front to the back
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] cnt;
        logic             rev;
        logic             send_end;
    } cmd_t;

    // bank handed back once its last word has been read
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

/* rtl/sgr_in_if.sv */
// sgr_in_if: input word channel of the stream group reverser
// depends on sgr_pkg for the data width

interface sgr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sgr_pkg::DATA_W-1:0]    item_value;
    logic                                 seq_end;

    modport source (output valid, output item_value, output seq_end, input ready);
    modport sink   (input valid, input item_value, input seq_end, output ready);
endinterface

/* rtl/sgr_out_if.sv */
// sgr_out_if: result word channel of the stream group reverser
// depends on sgr_pkg for the data width

interface sgr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sgr_pkg::DATA_W-1:0]    out_value;
    logic                                 run_last;
    logic                                 out_seq_end;

    modport source (output valid, output out_value, output run_last, output out_seq_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input out_seq_end,
                    output ready);
endinterface

/* rtl/sgr_front.sv */
// sgr_front: accepts words, fills the current bank, issues drain jobs
// depends on sgr_pkg and sgr_in_if

module sgr_front #(
    parameter int MAX_GROUP = 16,
    parameter int AW        = $clog2(MAX_GROUP)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sgr_in_if.sink                        in_ch,
    input  logic                          cfg_we,
    input  logic [sgr_pkg::CFG_W-1:0]     cfg_data,
    output logic                          wr_en,
    output logic [AW:0]                   wr_addr,
    output logic [sgr_pkg::DATA_W-1:0]    wr_data,
    output logic                          push,
    output sgr_pkg::cmd_t                 push_cmd,
    input  logic                          q_full,
    input  sgr_pkg::rel_t                 release_bank
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > sgr_pkg::CFG_W) ? CW : sgr_pkg::CFG_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);

    logic [sgr_pkg::CFG_W-1:0] group_size_reg;
    logic [CW-1:0]             fill_reg, fill_next;
    logic                      cur_bank_reg, cur_bank_next;
    logic [1:0]                busy_reg, busy_next;
    logic [KW-1:0]             k_eff;
    logic [CW-1:0]             n_cnt;
    logic                      accept, full_grp;

    // clamp group size into 1..MAX_GROUP
    always_comb
    begin
        if (group_size_reg == '0)
            k_eff = KW'(1);
        else if (KW'(group_size_reg) > MAX_K)
            k_eff = MAX_K;
        else
            k_eff = KW'(group_size_reg);
    end

    assign in_ch.ready = !busy_reg[cur_bank_reg] && !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign n_cnt       = fill_reg + CW'(1);
    assign full_grp    = KW'(n_cnt) >= k_eff;

    assign wr_en   = accept;
    assign wr_addr = {cur_bank_reg, fill_reg[AW-1:0]};
    assign wr_data = in_ch.item_value;

    assign push              = accept && (full_grp || in_ch.seq_end);
    assign push_cmd.bank     = cur_bank_reg;
    assign push_cmd.cnt      = sgr_pkg::CNT_W'(n_cnt);
    assign push_cmd.rev      = full_grp;
    assign push_cmd.send_end = in_ch.seq_end;

    always_comb
    begin
        fill_next     = fill_reg;
        cur_bank_next = cur_bank_reg;
        busy_next     = busy_reg;
        if (release_bank.valid)
            busy_next[release_bank.bank] = 1'b0;
        if (accept)
        begin
            if (push)
            begin
                fill_next                   = '0;
                cur_bank_next               = !cur_bank_reg;
                busy_next[cur_bank_reg]     = 1'b1;
            end
            else
                fill_next = n_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= sgr_pkg::GROUP_SIZE_RST;
            fill_reg       <= '0;
            cur_bank_reg   <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                group_size_reg <= cfg_data;
            fill_reg     <= fill_next;
            cur_bank_reg <= cur_bank_next;
            busy_reg     <= busy_next;
        end
    end

    // the queue has a slot for every bank, so a job never meets a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("drain job pushed into full queue");

    // a group always flushes before the bank overflows
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CW'(MAX_GROUP))
        else $error("fill count reached bank depth");

    // a released bank must be one that was handed over
    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        release_bank.valid |-> busy_reg[release_bank.bank])
        else $error("release of a bank that was not busy");

endmodule

/* rtl/sgr_queue.sv */
// sgr_queue: two-entry job queue between front and back
// depends on sgr_pkg for the job type

module sgr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sgr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          head_valid,
    output sgr_pkg::cmd_t head_cmd,
    output logic          full
);

    sgr_pkg::cmd_t ent_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg, cnt_next;

    assign head_valid = cnt_reg != 2'd0;
    assign head_cmd   = ent_reg[rd_ptr_reg];
    assign full       = cnt_reg == 2'd2;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/sgr_back.sv */
// sgr_back: two-bank word store and drain engine with output register
// depends on sgr_pkg and sgr_out_if

module sgr_back #(
    parameter int MAX_GROUP = 16,
    parameter int AW        = $clog2(MAX_GROUP)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [AW:0]                   wr_addr,
    input  logic [sgr_pkg::DATA_W-1:0]    wr_data,
    input  logic                          head_valid,
    input  sgr_pkg::cmd_t                 head_cmd,
    output logic                          pop,
    output sgr_pkg::rel_t                 release_bank,
    sgr_out_if.source                     out_ch
);

    localparam int DEPTH = 2 << AW;

    logic [sgr_pkg::DATA_W-1:0] mem [DEPTH];
    logic [sgr_pkg::DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]              idx_reg;
    logic                       valid_reg, last_reg, end_reg;
    logic                       advance, fire, is_last;
    logic [sgr_pkg::CNT_W-1:0]  last_idx;
    logic [AW-1:0]              rd_idx;

    assign advance  = !valid_reg || out_ch.ready;
    assign fire     = advance && head_valid;
    assign last_idx = head_cmd.cnt - sgr_pkg::CNT_W'(1);
    assign is_last  = sgr_pkg::CNT_W'(idx_reg) == last_idx;
    // reversed jobs read newest first
    assign rd_idx   = head_cmd.rev ? (last_idx[AW-1:0] - idx_reg) : idx_reg;

    assign pop                = fire && is_last;
    assign release_bank.valid = pop;
    assign release_bank.bank  = head_cmd.bank;

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_value   = rd_data_reg;
    assign out_ch.run_last    = last_reg;
    assign out_ch.out_seq_end = end_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (fire)
        begin
            rd_data_reg <= mem[{head_cmd.bank, rd_idx}];
            last_reg    <= is_last;
            end_reg     <= is_last && head_cmd.send_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (advance)
                valid_reg <= head_valid;
            if (fire)
                idx_reg <= is_last ? '0 : idx_reg + AW'(1);
        end
    end

    // every job covers between one word and a full bank
    a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_cmd.cnt != '0) &&
                       (head_cmd.cnt <= sgr_pkg::CNT_W'(MAX_GROUP)))
        else $error("drain job with bad word count");

endmodule

/* rtl/stream_group_reverser_top.sv */
// stream_group_reverser_top: top level of the stream group reverser
// depends on sgr_pkg, sgr_in_if, sgr_out_if, sgr_front, sgr_queue, sgr_back
//
// usage
//   in_ch carries one signed 32-bit word per handshake plus seq_end, which
//   marks the last word of a sequence. words gather into groups of
//   group_size (written through cfg_we / cfg_data, clamped to 1..MAX_GROUP).
//   a full group leaves on out_ch newest word first; when seq_end closes a
//   partial group its words leave in arrival order. run_last flags the last
//   result word of a group, out_seq_end the last word of a sequence.
// pipeline and throughput
//   a closed group's job is registered in the queue, then its words pass through
//   the output register, one result per cycle while out_ch is ready. two store
//   banks let one fill while the other drains, so full groups keep one word per
//   cycle in and out while out_ch is ready. the front stalls only when both banks
//   wait to drain, which short partial groups at sequence ends can cause.
// reset
//   group_size returns to 1 (pass-through), the fill count and queue empty.
//   the store itself is not cleared.
// stalls
//   while out_ch is held the output register keeps its word; the front keeps
//   taking words until the free bank is used up, then drops in_ch.ready.

module stream_group_reverser_top #(
    parameter int MAX_GROUP = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sgr_in_if.sink                        in_ch,
    sgr_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [sgr_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_GROUP);

    // store write port from front to back
    logic                       wr_en;
    logic [AW:0]                wr_addr;
    logic [sgr_pkg::DATA_W-1:0] wr_data;

    // job queue hookup
    logic          push, pop, q_full, head_valid;
    sgr_pkg::cmd_t push_cmd, head_cmd;
    sgr_pkg::rel_t release_bank;

    // front: classify words, fill banks
    sgr_front #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .push         (push),
        .push_cmd     (push_cmd),
        .q_full       (q_full),
        .release_bank (release_bank)
    );

    // jobs waiting for the drain engine
    sgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (q_full)
    );

    // back: drain one word per cycle into the output register while out_ch is ready
    sgr_back #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .release_bank (release_bank),
        .out_ch       (out_ch)
    );

endmodule
